// File: hw/rtl/hse_pkg.sv
package hse_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int ONE       = 1 << FB;
    localparam int DUR_W     = DW - 1;
    localparam int PH_W      = FB + 1;
    localparam logic [DUR_W-1:0] DUR_FLOOR = DUR_W'((ONE + 500) / 1000);
    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(ONE / 2);

    localparam int NW     = 62;
    localparam int QW     = NW + 1;
    localparam int CW     = FB + 6;
    localparam int PRW    = DW + 1 + CW;
    localparam int VV_W   = PRW - FB + 1;
    localparam int POS_W  = 56;
    localparam int ABC_W  = 48;
    localparam int SIDE_W = 144;

    localparam logic signed [63:0] SMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

    typedef enum logic [1:0] {
        PH_ZERO,
        PH_ONE,
        PH_DIV
    } ph_mode_t;

    typedef struct packed {
        logic [NW-1:0] mag;
        logic          neg;
    } dnum_t;

    typedef struct packed {
        dnum_t dpv;
        dnum_t dpa;
        dnum_t v1a;
        dnum_t v2a;
    } dset_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_sum;
        logic signed [VV_W-1:0]  vv;
        logic [PH_W-1:0]         s;
        dset_t                   d;
    } poly_out_t;

    typedef struct packed {
        logic [SIDE_W-3:0] pad;
        ph_mode_t          mode;
    } ph_side_t;

    typedef struct packed {
        logic [SIDE_W-POS_W-VV_W-PH_W-1:0] pad;
        logic signed [POS_W-1:0]           pos_sum;
        logic signed [VV_W-1:0]            vv;
        logic [PH_W-1:0]                   s;
    } mid_side_t;

    typedef struct packed {
        logic [SIDE_W-2*DW-ABC_W-PH_W-1:0] pad;
        logic signed [DW-1:0]              pos;
        logic signed [DW-1:0]              vel;
        logic signed [ABC_W-1:0]           abc;
        logic [PH_W-1:0]                   s;
    } fin_side_t;

    // round(x / ONE), half away from zero
    function automatic logic signed [VV_W-1:0] rnd_one(input logic signed [PRW-1:0] x);
        logic [PRW-1:0] m;
        logic [PRW-1:0] r;
        m = x[PRW-1] ? PRW'(-x) : PRW'(x);
        r = (m + PRW'(ONE / 2)) >> FB;
        rnd_one = x[PRW-1] ? -$signed(r[VV_W-1:0]) : $signed(r[VV_W-1:0]);
    endfunction

    function automatic dnum_t to_dnum(input logic signed [PRW-1:0] x);
        dnum_t d;
        d.neg = x[PRW-1];
        d.mag = x[PRW-1] ? NW'(-x) : NW'(x);
        to_dnum = d;
    endfunction

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [63:0] x);
        if (x > SMAX) begin
            sat_dw = DW'(SMAX);
        end else if (x < SMIN) begin
            sat_dw = DW'(SMIN);
        end else begin
            sat_dw = DW'(x);
        end
    endfunction

endpackage

// File: hw/rtl/hse_div.sv
module hse_div import hse_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [NW-1:0]         num,
    input  logic                  neg,
    input  logic [DUR_W-1:0]      den,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic signed [QW-1:0]  quot,
    output logic [SIDE_W-1:0]     side_out
);

    logic [NW+1:0]       vld_reg;
    logic [NW-1:0]       num_reg  [0:NW];
    logic [DUR_W-1:0]    rem_reg  [0:NW];
    logic [NW-1:0]       quo_reg  [0:NW];
    logic                neg_reg  [0:NW];
    logic [SIDE_W-1:0]   side_reg [0:NW];
    logic signed [QW-1:0] quot_reg;
    logic [SIDE_W-1:0]   side_o_reg;

    logic [DUR_W:0]      trial    [1:NW];
    logic                ge       [1:NW];
    logic [DUR_W-1:0]    rem_next [1:NW];

    always_comb begin
        for (int k = 1; k <= NW; k++) begin
            trial[k]    = {rem_reg[k-1], num_reg[k-1][NW-1]};
            ge[k]       = trial[k] >= {1'b0, den};
            rem_next[k] = ge[k] ? DUR_W'(trial[k] - {1'b0, den}) : DUR_W'(trial[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0]  <= num + NW'(den >> 1);
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= neg;
            side_reg[0] <= side_in;
            for (int k = 1; k <= NW; k++) begin
                num_reg[k]  <= num_reg[k-1] << 1;
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= {quo_reg[k-1][NW-2:0], ge[k]};
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            quot_reg   <= neg_reg[NW] ? -$signed({1'b0, quo_reg[NW]})
                                      : $signed({1'b0, quo_reg[NW]});
            side_o_reg <= side_reg[NW];
        end
    end

    assign out_valid = vld_reg[NW+1];
    assign quot      = quot_reg;
    assign side_out  = side_o_reg;

endmodule

// File: hw/rtl/hse_poly.sv
module hse_poly import hse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [PH_W-1:0]      s_in,
    input  logic signed [DW-1:0] p1,
    input  logic signed [DW-1:0] v1,
    input  logic signed [DW-1:0] p2,
    input  logic signed [DW-1:0] v2,
    input  logic [DUR_W-1:0]     dur,
    output logic                 out_valid,
    output poly_out_t            out
);

    logic [6:0] vld_reg;

    // stage 1
    logic [PH_W-1:0] s1_reg, s2_reg, s2_next;
    logic [2*PH_W-1:0] sq;
    // stage 2
    logic [PH_W-1:0] sa_reg, s2b_reg, s3_reg, s3_next;
    logic [2*PH_W-1:0] cu;
    // stage 3
    logic signed [CW-1:0] sc, s2c, s3c;
    logic [PH_W-1:0] sb_reg;
    logic signed [DW:0] dp_reg;
    logic signed [CW-1:0] c_h_reg, c_v1p_reg, c_v2p_reg, c_dpv_reg, c_v1v_reg;
    logic signed [CW-1:0] c_v2v_reg, c_dpa_reg, c_v1a_reg, c_v2a_reg;
    // stage 4
    logic [PH_W-1:0] s4_reg;
    logic signed [PRW-1:0] p_h_reg, p_v1p_reg, p_v2p_reg, p_dpv_reg, p_v1v_reg;
    logic signed [PRW-1:0] p_v2v_reg, p_dpa_reg, p_v1a_reg, p_v2a_reg;
    // stage 5
    logic [PH_W-1:0] s5_reg;
    logic signed [VV_W-1:0] h5_reg, w5_reg, vv5_reg;
    dset_t d5_reg;
    // stage 6
    logic [35:0] wm;
    logic [PH_W-1:0] s6_reg;
    logic signed [VV_W-1:0] h6_reg, vv6_reg;
    dset_t d6_reg;
    logic wneg6_reg;
    logic [DUR_W+17:0] pl_reg, ph_reg;
    // stage 7
    logic [67:0] wt, wr;
    logic signed [POS_W-1:0] post;
    poly_out_t out_reg, out_next;

    always_comb begin
        sq      = (2*PH_W)'(s_in) * (2*PH_W)'(s_in);
        s2_next = PH_W'((sq + (2*PH_W)'(ONE / 2)) >> FB);
        cu      = (2*PH_W)'(s2_reg) * (2*PH_W)'(s1_reg);
        s3_next = PH_W'((cu + (2*PH_W)'(ONE / 2)) >> FB);
        sc      = $signed(CW'(sa_reg));
        s2c     = $signed(CW'(s2b_reg));
        s3c     = $signed(CW'(s3_reg));
        wm      = w5_reg[VV_W-1] ? 36'(-w5_reg) : 36'(w5_reg);
        wt      = (68'(ph_reg) << 18) + 68'(pl_reg);
        wr      = (wt + 68'(ONE / 2)) >> FB;
        post    = wneg6_reg ? -$signed(POS_W'(wr)) : $signed(POS_W'(wr));
        out_next.pos_sum = POS_W'(p1) + POS_W'(h6_reg) + post;
        out_next.vv      = vv6_reg;
        out_next.s       = s6_reg;
        out_next.d       = d6_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg    <= s_in;
            s2_reg    <= s2_next;

            sa_reg    <= s1_reg;
            s2b_reg   <= s2_reg;
            s3_reg    <= s3_next;

            sb_reg    <= sa_reg;
            dp_reg    <= (DW+1)'(p2) - (DW+1)'(p1);
            c_h_reg   <= CW'(3 * s2c - 2 * s3c);
            c_v1p_reg <= CW'(s3c - 2 * s2c + sc);
            c_v2p_reg <= CW'(s3c - s2c);
            c_dpv_reg <= CW'(6 * sc - 6 * s2c);
            c_v1v_reg <= CW'(3 * s2c - 4 * sc + ONE);
            c_v2v_reg <= CW'(3 * s2c - 2 * sc);
            c_dpa_reg <= CW'(6 * ONE - 12 * sc);
            c_v1a_reg <= CW'(6 * sc - 4 * ONE);
            c_v2a_reg <= CW'(6 * sc - 2 * ONE);

            s4_reg    <= sb_reg;
            p_h_reg   <= dp_reg * c_h_reg;
            p_v1p_reg <= v1 * c_v1p_reg;
            p_v2p_reg <= v2 * c_v2p_reg;
            p_dpv_reg <= dp_reg * c_dpv_reg;
            p_v1v_reg <= v1 * c_v1v_reg;
            p_v2v_reg <= v2 * c_v2v_reg;
            p_dpa_reg <= dp_reg * c_dpa_reg;
            p_v1a_reg <= v1 * c_v1a_reg;
            p_v2a_reg <= v2 * c_v2a_reg;

            s5_reg     <= s4_reg;
            h5_reg     <= rnd_one(p_h_reg);
            w5_reg     <= rnd_one(p_v1p_reg) + rnd_one(p_v2p_reg);
            vv5_reg    <= rnd_one(p_v1v_reg) + rnd_one(p_v2v_reg);
            d5_reg.dpv <= to_dnum(p_dpv_reg);
            d5_reg.dpa <= to_dnum(p_dpa_reg);
            d5_reg.v1a <= to_dnum(p_v1a_reg);
            d5_reg.v2a <= to_dnum(p_v2a_reg);

            s6_reg    <= s5_reg;
            h6_reg    <= h5_reg;
            vv6_reg   <= vv5_reg;
            d6_reg    <= d5_reg;
            wneg6_reg <= w5_reg[VV_W-1];
            pl_reg    <= (DUR_W+18)'(wm[17:0]) * (DUR_W+18)'(dur);
            ph_reg    <= (DUR_W+18)'(wm[35:18]) * (DUR_W+18)'(dur);

            out_reg   <= out_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out       = out_reg;

endmodule

// File: hw/rtl/hermite_spline_evaluator.sv
// Cubic Hermite segment evaluator, one axis, signed Q16.16.
// Configuration: write start/end position, start/end velocity and duration
// through cfg_we/cfg_index/cfg_wdata while no transaction is in flight.
// Durations below 66 (0.001 s) act as 66.
// Input: one query time per s_ valid/ready transaction.
// Output: position, velocity, acceleration (saturated) and the clamped phase
// per m_ valid/ready transaction, in input order.
// Throughput: one transaction per cycle, sustained while m_ready does not stall the output.
// Pipeline: three chained radix-2 dividers of 64 stages each (phase,
// duration-scaled terms, second division of the acceleration term) plus the
// 7-stage polynomial pipeline.
// Stall: when m_ready is low with a result held, the whole pipeline freezes;
// the input register still takes one transaction if it is empty.
// Reset: aresetn (synchronous, active low) empties the pipeline and restores
// the default registers (all zero, duration 0.5 s).
module hermite_spline_evaluator import hse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [DW-1:0]        cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [DW-1:0] s_query_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [DW-1:0] m_position,
    output logic signed [DW-1:0] m_velocity,
    output logic signed [DW-1:0] m_acceleration,
    output logic [PH_W-1:0]      m_phase
);

    typedef enum logic [2:0] {
        CFG_START_POS,
        CFG_START_VEL,
        CFG_END_POS,
        CFG_END_VEL,
        CFG_DURATION
    } cfg_idx_t;

    logic signed [DW-1:0] p1_reg, v1_reg, p2_reg, v2_reg;
    logic [DUR_W-1:0]     dur_reg, dur_eff;

    logic                 en;
    logic                 t_vld_reg;
    logic signed [DW-1:0] t_reg;

    ph_side_t             ph_in, ph_out;
    logic [NW-1:0]        ph_num;
    logic                 ph_vld;
    logic signed [QW-1:0] ph_q;
    logic [SIDE_W-1:0]    ph_side_o;
    logic [PH_W-1:0]      s_val;

    logic                 pl_vld;
    poly_out_t            pl;
    mid_side_t            mid_in, mid_out;
    logic [SIDE_W-1:0]    mid_side_o;
    logic                 mid_vld;
    logic signed [QW-1:0] q_dpv, q_dpa, q_v1a, q_v2a;

    fin_side_t            fin_in, fin_out;
    logic [SIDE_W-1:0]    fin_side_o;
    logic [NW-1:0]        fin_num;
    logic [QW-1:0]        acc1_mag;
    logic                 fin_vld;
    logic signed [QW-1:0] q_fin;

    logic                 m_valid_reg;
    logic signed [DW-1:0] pos_reg, vel_reg, acc_reg;
    logic [PH_W-1:0]      phase_reg;

    assign dur_eff = (dur_reg < DUR_FLOOR) ? DUR_FLOOR : dur_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en || !t_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg  <= '0;
            v1_reg  <= '0;
            p2_reg  <= '0;
            v2_reg  <= '0;
            dur_reg <= DUR_RESET;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_POS: p1_reg  <= cfg_wdata;
                CFG_START_VEL: v1_reg  <= cfg_wdata;
                CFG_END_POS:   p2_reg  <= cfg_wdata;
                CFG_END_VEL:   v2_reg  <= cfg_wdata;
                CFG_DURATION:  dur_reg <= cfg_wdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_vld_reg <= 1'b0;
        end else if (s_ready) begin
            t_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            t_reg <= s_query_time;
        end
    end

    // phase: clamp, else divide t*ONE by the duration
    always_comb begin
        ph_in.pad = '0;
        if (t_reg <= 0) begin
            ph_in.mode = PH_ZERO;
        end else if ($unsigned(t_reg) >= DW'(dur_eff)) begin
            ph_in.mode = PH_ONE;
        end else begin
            ph_in.mode = PH_DIV;
        end
        ph_num = NW'(t_reg[DW-2:0]) << FB;
    end

    hse_div u_ph_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t_vld_reg),
        .num       (ph_num),
        .neg       (1'b0),
        .den       (dur_eff),
        .side_in   (SIDE_W'(ph_in)),
        .out_valid (ph_vld),
        .quot      (ph_q),
        .side_out  (ph_side_o)
    );

    always_comb begin
        ph_out = ph_side_t'(ph_side_o);
        case (ph_out.mode)
            PH_ZERO: s_val = '0;
            PH_ONE:  s_val = PH_W'(ONE);
            default: s_val = ph_q[PH_W-1:0];
        endcase
    end

    hse_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ph_vld),
        .s_in      (s_val),
        .p1        (p1_reg),
        .v1        (v1_reg),
        .p2        (p2_reg),
        .v2        (v2_reg),
        .dur       (dur_eff),
        .out_valid (pl_vld),
        .out       (pl)
    );

    always_comb begin
        mid_in.pad     = '0;
        mid_in.pos_sum = pl.pos_sum;
        mid_in.vv      = pl.vv;
        mid_in.s       = pl.s;
    end

    hse_div u_dpv_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pl_vld),
        .num       (pl.d.dpv.mag),
        .neg       (pl.d.dpv.neg),
        .den       (dur_eff),
        .side_in   (SIDE_W'(mid_in)),
        .out_valid (mid_vld),
        .quot      (q_dpv),
        .side_out  (mid_side_o)
    );

    hse_div u_dpa_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pl_vld),
        .num       (pl.d.dpa.mag),
        .neg       (pl.d.dpa.neg),
        .den       (dur_eff),
        .side_in   ('0),
        .out_valid (),
        .quot      (q_dpa),
        .side_out  ()
    );

    hse_div u_v1a_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pl_vld),
        .num       (pl.d.v1a.mag),
        .neg       (pl.d.v1a.neg),
        .den       (dur_eff),
        .side_in   ('0),
        .out_valid (),
        .quot      (q_v1a),
        .side_out  ()
    );

    hse_div u_v2a_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pl_vld),
        .num       (pl.d.v2a.mag),
        .neg       (pl.d.v2a.neg),
        .den       (dur_eff),
        .side_in   ('0),
        .out_valid (),
        .quot      (q_v2a),
        .side_out  ()
    );

    always_comb begin
        mid_out    = mid_side_t'(mid_side_o);
        fin_in.pad = '0;
        fin_in.pos = sat_dw(64'(mid_out.pos_sum));
        fin_in.vel = sat_dw(64'(q_dpv) + 64'(mid_out.vv));
        fin_in.abc = ABC_W'(q_v1a + q_v2a);
        fin_in.s   = mid_out.s;
        acc1_mag   = q_dpa[QW-1] ? QW'(-q_dpa) : QW'(q_dpa);
        fin_num    = NW'(acc1_mag) << FB;
    end

    hse_div u_fin_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mid_vld),
        .num       (fin_num),
        .neg       (q_dpa[QW-1]),
        .den       (dur_eff),
        .side_in   (SIDE_W'(fin_in)),
        .out_valid (fin_vld),
        .quot      (q_fin),
        .side_out  (fin_side_o)
    );

    assign fin_out = fin_side_t'(fin_side_o);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= fin_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg   <= fin_out.pos;
            vel_reg   <= fin_out.vel;
            acc_reg   <= sat_dw(64'(q_fin) + 64'(fin_out.abc));
            phase_reg <= fin_out.s;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_position     = pos_reg;
    assign m_velocity     = vel_reg;
    assign m_acceleration = acc_reg;
    assign m_phase        = phase_reg;

endmodule
